// ===== rtl/core/mtrr_pkg.sv =====
// ----------------------------------------------------------------------------
// mtrr_pkg: shared types and constants of the memory-type range table
// Command and status codes, payload structs and table sizing.
// ----------------------------------------------------------------------------
package mtrr_pkg;

   localparam int MaxRangesDefault = 8;

   localparam logic [63:0] OneMb     = 64'h0000_0000_0010_0000;
   localparam logic [63:0] FourKb    = 64'h0000_0000_0000_1000;
   localparam logic [63:0] ValidBit  = 64'h0000_0000_0000_0800;
   localparam logic [63:0] LowBits   = 64'h0000_0000_0000_0FFF;
   localparam logic [63:0] TypeBits  = 64'h0000_0000_0000_00FF;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_PRESET = 2'd2,
      CMD_BAD    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOT_SUPP = 3'd1,
      ST_INVALID  = 3'd2,
      ST_NO_SPACE = 3'd3,
      ST_NOT_FND  = 3'd4
   } status_type;

   localparam logic [7:0] T_UC = 8'd0;
   localparam logic [7:0] T_WC = 8'd1;
   localparam logic [7:0] T_WT = 8'd4;
   localparam logic [7:0] T_WP = 8'd5;
   localparam logic [7:0] T_WB = 8'd6;

   localparam logic [1:0] CSR_ENABLED = 2'd0;
   localparam logic [1:0] CSR_WC      = 2'd1;
   localparam logic [1:0] CSR_RANGES  = 2'd2;
   localparam logic [1:0] CSR_PHYS    = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [51:0] address;
      logic [52:0] length;
      logic [7:0]  mem_type;
      logic [2:0]  slot;
      logic [63:0] preset_base;
      logic [63:0] preset_mask;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        hw_update;
      logic [2:0]  touched_slot;
      logic [63:0] entry_base;
      logic [63:0] entry_mask;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_DONE,
      S_CLEAR
   } fsm_type;

endpackage

// ===== rtl/core/memory_type_range_table.sv =====
// ----------------------------------------------------------------------------
// memory_type_range_table: reference-counted memory-type range allocator
// Sequence: preset and rejected words go from accept through S_CHECK and S_DONE
// to response valid; add/remove pass S_CHECK, then S_READ and S_DONE per entry.
// Throughput: one word at a time; a new request is taken the cycle after the
// response is taken. The scan reads each table entry in S_READ, checks it in S_DONE.
// Reset: synchronous; after reset a clearing pass zeroes each entry of the
// entry memory, during which no request word is taken.
// ----------------------------------------------------------------------------
module memory_type_range_table #(
   parameter int MAX_RANGES = mtrr_pkg::MaxRangesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mtrr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mtrr_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [5:0]       csr_wdata
);
   import mtrr_pkg::*;

   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   // room for the end-of-scan marker MAX_RANGES + 1
   localparam int CW = $clog2(MAX_RANGES + 2);

   // entry memory: base, mask, count
   logic [143:0] mem [MAX_RANGES];
   logic [143:0] rd_ff;
   logic         we;
   logic [IW-1:0] waddr, raddr;
   logic [143:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // configuration
   logic       en_ff, wc_ff;
   logic [3:0] rng_ff;
   logic [5:0] pab_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0; wc_ff <= 1'b0; rng_ff <= 4'd0; pab_ff <= 6'd36;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLED: en_ff  <= csr_wdata[0];
            CSR_WC:      wc_ff  <= csr_wdata[0];
            CSR_RANGES:  rng_ff <= csr_wdata[3:0];
            CSR_PHYS:    pab_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [CW-1:0] live;
   assign live = (32'(rng_ff) < MAX_RANGES) ? CW'(rng_ff) : CW'(MAX_RANGES);

   logic [5:0] pb;
   assign pb = (pab_ff < 6'd36) ? 6'd36 : ((pab_ff > 6'd52) ? 6'd52 : pab_ff);
   logic [63:0] pmask, bmask;
   assign pmask = (64'd1 << pb) - 64'd1;
   assign bmask = pmask & ~LowBits;

   // state
   fsm_type st_ff, st_in;
   req_type q_ff;
   rsp_type r_ff, r_in;
   logic [CW-1:0] i_ff, i_in;
   logic          fnd_ff, fnd_in;
   logic [IW-1:0] fi_ff, fi_in;
   logic          rv_ff, rv_in;

   logic [63:0] a, l;
   assign a = {12'd0, q_ff.address};
   assign l = {11'd0, q_ff.length};

   // current entry decode and compare
   logic [63:0] eb, em, va, vl;
   logic [15:0] ec;
   logic [7:0]  vt;
   logic        ovl, ident, allow;
   assign eb = rd_ff[143:80];
   assign em = rd_ff[79:16];
   assign ec = rd_ff[15:0];
   assign va = eb & bmask;
   assign vt = eb[7:0];
   assign vl = (~(em & bmask) & pmask) + 64'd1;
   assign ovl = (va >= a && va < a + l) || (a >= va && a < va + vl);
   assign ident = va == a && vl == l && vt == q_ff.mem_type;
   assign allow = (vt == T_UC && q_ff.mem_type == T_UC) ||
                  (vt == T_UC && q_ff.mem_type == T_WB) ||
                  (vt == T_WB && q_ff.mem_type == T_UC);

   logic [63:0] enc_b, enc_m;
   assign enc_b = (a & bmask) | {56'd0, q_ff.mem_type};
   assign enc_m = ~(l - 64'd1) & bmask;

   // add argument checks
   logic type_ok, pow2, al_ok;
   assign type_ok = q_ff.mem_type == T_UC || q_ff.mem_type == T_WC ||
                    q_ff.mem_type == T_WT || q_ff.mem_type == T_WP ||
                    q_ff.mem_type == T_WB;
   assign pow2 = (l & (l - 64'd1)) == 64'd0;
   assign al_ok = (a == 64'd0) || (l <= (a & (~a + 64'd1)));

   function automatic rsp_type fail(status_type s);
      rsp_type r;
      r = '0;
      r.status = s;
      return r;
   endfunction

   function automatic rsp_type good(logic hw, logic [IW-1:0] s,
                                    logic [63:0] b, logic [63:0] m);
      rsp_type r;
      r.status = ST_OK;
      r.hw_update = hw;
      r.touched_slot = 3'(s);
      r.entry_base = b;
      r.entry_mask = m;
      return r;
   endfunction

   // control
   always_comb begin
      st_in = st_ff; r_in = r_ff; i_in = i_ff; fnd_in = fnd_ff; fi_in = fi_ff;
      rv_in = rv_ff; we = 1'b0; waddr = fi_ff; wdata = '0;
      raddr = i_ff[IW-1:0];
      req_ready = (st_ff == S_IDLE) && !rv_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (st_ff)
         S_CLEAR: begin
            we = 1'b1; waddr = i_ff[IW-1:0];
            i_in = i_ff + CW'(1);
            if (i_ff == CW'(MAX_RANGES - 1)) begin
               st_in = S_IDLE; i_in = '0;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               st_in = S_CHECK; i_in = '0; fnd_in = 1'b0; fi_in = '0;
               r_in = '0;
            end
         end
         S_CHECK: begin
            // setup decision before scan
            st_in = S_READ;
            if (!en_ff) begin
               r_in = fail(ST_NOT_SUPP); st_in = S_DONE;
            end else if (q_ff.command == CMD_PRESET) begin
               if (32'(q_ff.slot) >= 32'(live)) begin
                  r_in = fail(ST_INVALID);
               end else begin
                  we = 1'b1; waddr = IW'(q_ff.slot);
                  wdata = {q_ff.preset_base, q_ff.preset_mask,
                           15'd0, (q_ff.preset_mask & ValidBit) != 64'd0};
                  r_in = good(1'b0, IW'(q_ff.slot), q_ff.preset_base,
                              q_ff.preset_mask);
               end
               st_in = S_DONE;
            end else if (q_ff.command == CMD_ADD) begin
               if (!type_ok) begin
                  r_in = fail(ST_INVALID); st_in = S_DONE;
               end else if (q_ff.mem_type == T_WC && !wc_ff) begin
                  r_in = fail(ST_NOT_SUPP); st_in = S_DONE;
               end else if (a < OneMb || live == '0) begin
                  r_in = fail(ST_NOT_SUPP); st_in = S_DONE;
               end else if (l < FourKb || !pow2 || !al_ok) begin
                  r_in = fail(ST_INVALID); st_in = S_DONE;
               end
            end else if (q_ff.command == CMD_REMOVE) begin
               if (live == '0) begin
                  r_in = fail(ST_NOT_FND); st_in = S_DONE;
               end
            end else begin
               r_in = fail(ST_INVALID); st_in = S_DONE;
            end
         end
         S_READ: begin
            // memory address i presented; entry data valid in S_DONE
            st_in = S_DONE;
         end
         S_DONE: begin
            if (q_ff.command == CMD_PRESET || !en_ff || r_ff.status != ST_OK
                || q_ff.command == CMD_BAD || i_ff == CW'(MAX_RANGES + 1)) begin
               // result ready
               rv_in = 1'b1; st_in = S_IDLE;
            end else begin
               // evaluate entry i
               st_in = S_READ;
               i_in = i_ff + CW'(1);
               if (q_ff.command == CMD_ADD) begin
                  if (ec == 16'd0) begin
                     fnd_in = 1'b1; fi_in = i_ff[IW-1:0];
                  end else if (ovl && ident) begin
                     we = 1'b1; waddr = i_ff[IW-1:0];
                     wdata = {eb, em, (ec == 16'hFFFF) ? ec : ec + 16'd1};
                     r_in = good(1'b0, i_ff[IW-1:0], eb, em);
                     i_in = CW'(MAX_RANGES + 1);
                  end else if (ovl && !allow) begin
                     r_in = fail(ST_NO_SPACE); i_in = CW'(MAX_RANGES + 1);
                  end
                  if (i_in != CW'(MAX_RANGES + 1) && i_ff + CW'(1) >= live) begin
                     i_in = CW'(MAX_RANGES + 1);
                     if (ec == 16'd0 || fnd_ff) begin
                        we = 1'b1;
                        waddr = (ec == 16'd0) ? i_ff[IW-1:0] : fi_ff;
                        wdata = {enc_b, enc_m | ValidBit, 16'd1};
                        r_in = good(1'b1, waddr, enc_b, enc_m | ValidBit);
                     end else begin
                        r_in = fail(ST_NO_SPACE);
                     end
                  end
               end else begin
                  if (ec != 16'd0 && ovl && ident) begin
                     we = 1'b1; waddr = i_ff[IW-1:0];
                     i_in = CW'(MAX_RANGES + 1);
                     if (ec == 16'd1) begin
                        wdata = {enc_b, enc_m, 16'd0};
                        r_in = good(1'b1, i_ff[IW-1:0], enc_b, enc_m);
                     end else begin
                        wdata = {eb, em, ec - 16'd1};
                        r_in = good(1'b0, i_ff[IW-1:0], eb, em);
                     end
                  end else if (i_ff + CW'(1) >= live) begin
                     r_in = fail(ST_NOT_FND); i_in = CW'(MAX_RANGES + 1);
                  end
               end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; i_ff <= '0; rv_ff <= 1'b0; fnd_ff <= 1'b0; fi_ff <= '0;
      end else begin
         st_ff <= st_in; i_ff <= i_in; rv_ff <= rv_in; fnd_ff <= fnd_in;
         fi_ff <= fi_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      if (req_valid && req_ready) q_ff <= req_data;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = r_ff;

   // checks
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req_ready) else $error("request taken with result pending");
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && r_ff.status != ST_OK) |-> (!r_ff.hw_update && r_ff.entry_base == 64'd0))
      else $error("failure result carries data");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_ready) |=> (rv_ff && $stable(r_ff)))
      else $error("result changed while stalled");

endmodule
